// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the top-level RTL file, all clocked on aclk and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// The condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/iirtdf2_pkg.sv -----
// Shared constants, types and saturation helpers of the transposed direct form II IIR filter.
package iirtdf2_pkg;

    localparam int MAX_COEFFS  = 4;
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 24;
    localparam int DELAY_W     = 32;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ROUND_SHIFT = 21;
    localparam int RND_W       = PROD_W - ROUND_SHIFT;
    localparam int COUNT_W     = 3;
    localparam int COEF_IDX_W  = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [COUNT_W-1:0]       COUNT_RESET = 3'd3;
    localparam logic signed [COEF_W-1:0] B0_RESET    = 24'sd2097152;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = 48'sd1048576;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT = 3'd0,
        CFG_B0    = 3'd1,
        CFG_B1    = 3'd2,
        CFG_B2    = 3'd3,
        CFG_B3    = 3'd4,
        CFG_A1    = 3'd5,
        CFG_A2    = 3'd6,
        CFG_A3    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       coeff_count;
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] b3;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
    } cfg_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic                  load_x;
        logic                  mul_en;
        logic                  mul_fb;
        logic                  y_en;
        logic                  acc_en;
        logic                  use_next;
        logic                  d_wr;
        logic                  d_clr;
        logic                  out_load;
        logic [COEF_IDX_W-1:0] coef_idx;
    } cmd_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [DELAY_W:0] v
    );
        if (v > 33'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -33'sd8388608) begin
            return -24'sd8388608;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [DELAY_W+1:0] v
    );
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DELAY_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/iirtdf2_cfg.sv -----
// Configuration register file: coefficient count and filter coefficients.
module iirtdf2_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [iirtdf2_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [iirtdf2_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output iirtdf2_pkg::cfg_t                    cfg
);

    iirtdf2_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeff_count <= iirtdf2_pkg::COUNT_RESET;
            cfg_reg.b0          <= iirtdf2_pkg::B0_RESET;
            cfg_reg.b1          <= '0;
            cfg_reg.b2          <= '0;
            cfg_reg.b3          <= '0;
            cfg_reg.a1          <= '0;
            cfg_reg.a2          <= '0;
            cfg_reg.a3          <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                iirtdf2_pkg::CFG_COUNT: begin
                    cfg_reg.coeff_count <= cfg_wr_data[iirtdf2_pkg::COUNT_W-1:0];
                end
                iirtdf2_pkg::CFG_B0: cfg_reg.b0 <= cfg_wr_data;
                iirtdf2_pkg::CFG_B1: cfg_reg.b1 <= cfg_wr_data;
                iirtdf2_pkg::CFG_B2: cfg_reg.b2 <= cfg_wr_data;
                iirtdf2_pkg::CFG_B3: cfg_reg.b3 <= cfg_wr_data;
                iirtdf2_pkg::CFG_A1: cfg_reg.a1 <= cfg_wr_data;
                iirtdf2_pkg::CFG_A2: cfg_reg.a2 <= cfg_wr_data;
                iirtdf2_pkg::CFG_A3: cfg_reg.a3 <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/iirtdf2_ctrl.sv -----
// Sequencer of the filter: steps the shared multiplier through the taps of one item.
module iirtdf2_ctrl #(
    parameter int MAX_COEFFS = iirtdf2_pkg::MAX_COEFFS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [iirtdf2_pkg::COUNT_W-1:0]    coeff_count,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output iirtdf2_pkg::cmd_t                  cmd
);

    localparam int TW = $clog2(MAX_COEFFS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_Y,
        ST_MUL_B,
        ST_ACC,
        ST_MUL_A,
        ST_DWR,
        ST_CLR,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [TW-1:0] tap_reg, tap_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0] n_last;

    // Index of the last tap in use, with the count clamped to its legal range.
    always_comb begin
        if (coeff_count < 3'd2) begin
            n_last = TW'(1);
        end else if (coeff_count > 3'(MAX_COEFFS)) begin
            n_last = TW'(MAX_COEFFS - 1);
        end else begin
            n_last = TW'(coeff_count - 3'd1);
        end
    end

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.coef_idx  = iirtdf2_pkg::COEF_IDX_W'(tap_reg);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_x = 1'b1;
                    tap_next   = '0;
                    state_next = ST_MUL_B0;
                end
            end
            ST_MUL_B0: begin
                cmd.mul_en = 1'b1;
                state_next = ST_Y;
            end
            ST_Y: begin
                cmd.y_en   = 1'b1;
                tap_next   = TW'(1);
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en   = 1'b1;
                cmd.use_next = (tap_reg < n_last);
                state_next   = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_en = 1'b1;
                cmd.mul_fb = 1'b1;
                state_next = ST_DWR;
            end
            ST_DWR: begin
                cmd.d_wr = 1'b1;
                if (tap_reg == n_last) begin
                    // Delay registers past the count in use are cleared one per cycle.
                    if (n_last != TW'(MAX_COEFFS - 1)) begin
                        state_next = ST_CLR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    tap_next   = tap_reg + TW'(1);
                    state_next = ST_MUL_B;
                end
            end
            ST_CLR: begin
                cmd.d_clr = 1'b1;
                if (tap_reg == TW'(MAX_COEFFS - 2)) begin
                    state_next = ST_DONE;
                end else begin
                    tap_next = tap_reg + TW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/iirtdf2_dp.sv -----
// Datapath of the filter: shared multiplier, rounding, delay registers and output register.
module iirtdf2_dp #(
    parameter int MAX_COEFFS = iirtdf2_pkg::MAX_COEFFS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  iirtdf2_pkg::cmd_t                         cmd,
    input  iirtdf2_pkg::cfg_t                         cfg,
    input  logic signed [iirtdf2_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                      last_in,
    output logic signed [iirtdf2_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                      last_out
);

    localparam int SW     = iirtdf2_pkg::SAMPLE_W;
    localparam int DW     = iirtdf2_pkg::DELAY_W;
    localparam int PW     = iirtdf2_pkg::PROD_W;
    localparam int RW     = iirtdf2_pkg::RND_W;
    localparam int DEPTH  = MAX_COEFFS - 1;
    localparam int DIDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [SW-1:0] x_reg;
    logic                 last_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW:0]   acc_reg;
    logic signed [DW-1:0] d_reg [DEPTH];
    logic signed [SW-1:0] out_sample_reg;
    logic                 out_last_reg;

    logic signed [iirtdf2_pkg::COEF_W-1:0] coef_sel;
    logic signed [SW-1:0]                  mul_op;
    logic signed [PW-1:0]                  prod_next;
    logic signed [PW-1:0]                  prod_rnd;
    logic signed [RW-1:0]                  rnd;
    logic [DIDX_W-1:0]                     d_rd_idx;
    logic [DIDX_W-1:0]                     d_wr_idx;
    logic signed [DW:0]                    y_sum;
    logic signed [DW:0]                    acc_next;
    logic signed [DW+1:0]                  d_sum;

    always_comb begin
        if (cmd.mul_fb) begin
            case (cmd.coef_idx)
                2'd1:    coef_sel = cfg.a1;
                2'd2:    coef_sel = cfg.a2;
                2'd3:    coef_sel = cfg.a3;
                default: coef_sel = '0;
            endcase
        end else begin
            case (cmd.coef_idx)
                2'd0:    coef_sel = cfg.b0;
                2'd1:    coef_sel = cfg.b1;
                2'd2:    coef_sel = cfg.b2;
                2'd3:    coef_sel = cfg.b3;
                default: coef_sel = '0;
            endcase
        end
    end

    assign mul_op    = cmd.mul_fb ? y_reg : x_reg;
    assign prod_next = PW'(mul_op) * PW'(coef_sel);

    // Round half up, dropping the 21 fractional bits of the coefficient.
    assign prod_rnd = prod_reg + iirtdf2_pkg::ROUND_HALF;
    assign rnd      = prod_rnd[PW-1:iirtdf2_pkg::ROUND_SHIFT];

    assign d_rd_idx = DIDX_W'(cmd.coef_idx);
    assign d_wr_idx = DIDX_W'(cmd.coef_idx - 2'd1);

    assign y_sum    = (DW+1)'(rnd) + (DW+1)'(d_reg[0]);
    assign acc_next = (DW+1)'(rnd) + (cmd.use_next ? (DW+1)'(d_reg[d_rd_idx]) : '0);
    assign d_sum    = (DW+2)'(acc_reg) - (DW+2)'(rnd);

    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg    <= sample_in;
            last_reg <= last_in;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.y_en) begin
            y_reg <= iirtdf2_pkg::sat_sample(y_sum);
        end
        if (cmd.acc_en) begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load) begin
            out_sample_reg <= y_reg;
            out_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                d_reg[i] <= '0;
            end
        end else if (cmd.d_wr) begin
            d_reg[d_wr_idx] <= iirtdf2_pkg::sat_delay(d_sum);
        end else if (cmd.d_clr) begin
            d_reg[d_rd_idx] <= '0;
        end
    end

    assign sample_out = out_sample_reg;
    assign last_out   = out_last_reg;

endmodule

// ----- hw/rtl/iir_transposed_direct_form_two.sv -----
// Top level of the transposed direct form II IIR filter with saturating fixed-point arithmetic.
//
//  port group     dir  fields (low bit up)               accepted when
//  s_t*           in   tdata: sample_in[23:0]; tlast     s_tvalid && s_tready
//  m_t*           out  tdata: sample_out[23:0]; tlast    m_tvalid && m_tready
//  cfg_wr_*       in   index 0..7, data up to 24 bits    cfg_wr_en
//
// One shared 24x24 multiplier computes every product of an item in turn, so a new item
// is taken only after the last one has been loaded into the output register.
// A finished item waits in the output register; the next item is taken meanwhile
// and only holds in its last step while that register is still full.
// Reset (aresetn low at a clock edge) clears the delay registers and loads the
// default coefficients; no clearing pass follows.
module iir_transposed_direct_form_two #(
    parameter int MAX_COEFFS = iirtdf2_pkg::MAX_COEFFS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,   // sample_in[23:0]
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [23:0]                           m_tdata,   // sample_out[23:0]
    output logic                                  m_tlast,
    input  logic                                  cfg_wr_en,
    input  logic [iirtdf2_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [iirtdf2_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    iirtdf2_pkg::cfg_t cfg;
    iirtdf2_pkg::cmd_t cmd;

    iirtdf2_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    iirtdf2_ctrl #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .coeff_count (cfg.coeff_count),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd)
    );

    iirtdf2_dp #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (s_tdata),
        .last_in    (s_tlast),
        .sample_out (m_tdata),
        .last_out   (m_tlast)
    );

`include "assert_macros.svh"

    `ASSERT_CLK(a_one_item_at_a_time, s_tvalid && s_tready |=> !s_tready, "item taken while busy")
    `ASSERT_CLK(a_y_after_product, cmd.y_en |-> $past(cmd.mul_en), "output sum without product")
    `ASSERT_CLK(a_dwr_after_fb, cmd.d_wr |-> $past(cmd.mul_en && cmd.mul_fb), "early delay write")
    `ASSERT_NEVER(a_no_overwrite, cmd.out_load && m_tvalid && !m_tready, "result overwritten")

endmodule
